/* sv/wfa_pkg.sv */
// ----------------------------------------------------------------------------
// Worst-fit allocator package
// Shared constants, word types, state encoding and the control/status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package wfa_pkg;

    localparam int MAX_BLOCKS_DEF = 16;
    localparam int SIZE_WIDTH_DEF = 16;

    typedef enum logic [1:0] {
        ST_ALLOCATED     = 2'd0,
        ST_NOT_ALLOCATED = 2'd1,
        ST_LOADED        = 2'd2,
        ST_FULL          = 2'd3
    } status_t;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_REQUEST = 1'b1
    } op_t;

    typedef struct packed {
        logic        op;
        logic [15:0] amount;
    } req_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  block_index;
        logic [15:0] left_over;
    } rsp_word_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } state_t;

    typedef struct packed {
        logic capture;      // latch the incoming word and restart the scan
        logic rd_issue;     // read the next table entry
        logic finish_load;  // store a block and write the load result
        logic finish_req;   // commit the allocation and write its result
    } ctrl_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

/* sv/wfa_ctrl.sv */
// ----------------------------------------------------------------------------
// Worst-fit allocator controller
// Sequences one word at a time: load, or for a request a scan of the table
// (skipped when it is empty) followed by the allocation decision, each result waiting for a free output register.
// ----------------------------------------------------------------------------
module wfa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_op,
    output logic               req_stall,
    input  wfa_pkg::ctrl_sts_t sts,
    output wfa_pkg::ctrl_cmd_t cmd
);

    wfa_pkg::state_t state_reg;
    wfa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wfa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            wfa_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    if (req_op == wfa_pkg::OP_LOAD)
                    begin
                        state_next = wfa_pkg::S_LOAD;
                    end
                    else if (sts.count_zero)
                    begin
                        state_next = wfa_pkg::S_DECIDE;
                    end
                    else
                    begin
                        state_next = wfa_pkg::S_SCAN;
                    end
                end
            end
            wfa_pkg::S_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.finish_load = 1'b1;
                    state_next      = wfa_pkg::S_IDLE;
                end
            end
            wfa_pkg::S_SCAN:
            begin
                cmd.rd_issue = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = wfa_pkg::S_DRAIN;
                end
            end
            wfa_pkg::S_DRAIN:
            begin
                // The last entry read is compared in this cycle.
                state_next = wfa_pkg::S_DECIDE;
            end
            wfa_pkg::S_DECIDE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish_req = 1'b1;
                    state_next     = wfa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = wfa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* sv/wfa_dp.sv */
// ----------------------------------------------------------------------------
// Worst-fit allocator datapath
// Block size table, fill count, largest-block scan and the output register.
// ----------------------------------------------------------------------------
module wfa_dp #(
    parameter int MAX_BLOCKS = wfa_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_WIDTH = wfa_pkg::SIZE_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  wfa_pkg::req_word_t req_word,
    input  wfa_pkg::ctrl_cmd_t cmd,
    output wfa_pkg::ctrl_sts_t sts,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output wfa_pkg::rsp_word_t rsp_word
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    logic [SIZE_WIDTH-1:0] mem [MAX_BLOCKS];

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      rd_ptr_reg;
    logic                  rd_vld_reg;
    logic                  out_valid_reg;

    logic [SIZE_WIDTH-1:0] amt_reg;
    logic [SIZE_WIDTH-1:0] rd_data_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic [SIZE_WIDTH-1:0] best_size_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    wfa_pkg::rsp_word_t    out_word_reg;

    logic [31:0]           amt_wide;
    logic [SIZE_WIDTH-1:0] amt_in;
    logic                  full;
    logic                  fits;
    logic [SIZE_WIDTH-1:0] remainder;
    logic [31:0]           rem_wide;
    logic [31:0]           amt_reg_wide;
    logic [31:0]           load_idx_wide;
    logic [31:0]           best_idx_wide;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [SIZE_WIDTH-1:0] mem_wdata;

    assign amt_wide      = 32'(req_word.amount);
    assign amt_in        = amt_wide[SIZE_WIDTH-1:0];
    assign full          = (count_reg == CNT_W'(MAX_BLOCKS));
    assign fits          = (count_reg != '0) && (amt_reg <= best_size_reg);
    assign remainder     = best_size_reg - amt_reg;
    assign rem_wide      = 32'(remainder);
    assign amt_reg_wide  = 32'(amt_reg);
    assign load_idx_wide = 32'(count_reg);
    assign best_idx_wide = 32'(best_idx_reg);

    assign sts.count_zero = (count_reg == '0);
    assign sts.scan_last  = (rd_ptr_reg == count_reg - CNT_W'(1));
    assign sts.out_free   = !out_valid_reg || !rsp_stall;

    assign mem_we    = (cmd.finish_load && !full) || (cmd.finish_req && fits);
    assign mem_waddr = cmd.finish_load ? count_reg[IDX_W-1:0] : best_idx_reg;
    assign mem_wdata = cmd.finish_load ? amt_reg : remainder;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[rd_ptr_reg[IDX_W-1:0]];
            rd_idx_reg  <= rd_ptr_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd_issue;
            if (cmd.capture)
            begin
                rd_ptr_reg <= '0;
            end
            else if (cmd.rd_issue)
            begin
                rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
            end
            if (cmd.finish_load && !full)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.finish_load || cmd.finish_req)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            amt_reg <= amt_in;
        end
        // The first entry seeds the running maximum; a strict compare keeps
        // the lowest index on a tie.
        if (rd_vld_reg && ((rd_idx_reg == '0) || (rd_data_reg > best_size_reg)))
        begin
            best_size_reg <= rd_data_reg;
            best_idx_reg  <= rd_idx_reg;
        end
        if (cmd.finish_load)
        begin
            if (full)
            begin
                out_word_reg.status      <= wfa_pkg::ST_FULL;
                out_word_reg.block_index <= '0;
                out_word_reg.left_over   <= '0;
            end
            else
            begin
                out_word_reg.status      <= wfa_pkg::ST_LOADED;
                out_word_reg.block_index <= load_idx_wide[3:0];
                out_word_reg.left_over   <= amt_reg_wide[15:0];
            end
        end
        else if (cmd.finish_req)
        begin
            if (fits)
            begin
                out_word_reg.status      <= wfa_pkg::ST_ALLOCATED;
                out_word_reg.block_index <= best_idx_wide[3:0];
                out_word_reg.left_over   <= rem_wide[15:0];
            end
            else
            begin
                out_word_reg.status      <= wfa_pkg::ST_NOT_ALLOCATED;
                out_word_reg.block_index <= '0;
                out_word_reg.left_over   <= '0;
            end
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

endmodule

/* sv/worst_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// Worst-fit block allocator
// Load word: stored and its result written once the output register is free.
// Request word: a scan of the size table, one entry per cycle and skipped when
// empty, then the allocation decision. One word is in work at a time; the next
// is taken while a result waits. Reset empties the table and output register.
// ----------------------------------------------------------------------------
module worst_fit_block_allocator #(
    parameter int MAX_BLOCKS = wfa_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_WIDTH = wfa_pkg::SIZE_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  wfa_pkg::req_word_t req_word,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output wfa_pkg::rsp_word_t rsp_word
);

    wfa_pkg::ctrl_cmd_t cmd;
    wfa_pkg::ctrl_sts_t sts;

    wfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_op    (req_word.op),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    wfa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_word  (req_word),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    // A word taken in leaves the block busy, so it stalls before it takes another word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("accepted a second word while busy");

    // A result is never written over one that is still stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish_load || cmd.finish_req) |-> !(rsp_valid && rsp_stall))
        else $error("result register overwritten while stalled");

    // Refusals carry neither an index nor a size.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_word.status == wfa_pkg::ST_NOT_ALLOCATED ||
                       rsp_word.status == wfa_pkg::ST_FULL))
        |-> (rsp_word.block_index == '0 && rsp_word.left_over == '0))
        else $error("refused word carries index or size");

    // The scan runs only while a request is being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |-> (req_stall && !cmd.finish_req && !cmd.finish_load))
        else $error("table read outside a request scan");

endmodule

/* verif/wfa_allocation_checker.sv */
// ----------------------------------------------------------------------------
// Worst-fit allocator checker
// Watches both channels of the allocator. For every accepted input word it
// updates its own copy of the block table and queues the result that the
// word should give. Every accepted result word is then compared, field by
// field, with the oldest queued result.
// ----------------------------------------------------------------------------
module wfa_allocation_checker #(
    parameter int MAX_BLOCKS = wfa_pkg::MAX_BLOCKS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_stall,
    input  wfa_pkg::req_word_t req_word,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  wfa_pkg::rsp_word_t rsp_word,
    output int                 mismatch_count,
    output int                 results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MISMATCH_REPORTS = 10;

    logic [15:0]        block_free [MAX_BLOCKS];
    int unsigned        blocks_in_table = 0;
    wfa_pkg::rsp_word_t expected_results [$];
    int                 mismatch_total = 0;
    int                 owed_words = 0;

    assign mismatch_count = mismatch_total;
    assign results_owed   = owed_words;

    // Applies one input word to the table copy and returns its result word.
    function automatic wfa_pkg::rsp_word_t allocate_or_load(input wfa_pkg::req_word_t w);
        wfa_pkg::rsp_word_t r;
        int unsigned        best;
        int unsigned        i;
        r = '0;
        if (w.op == wfa_pkg::OP_LOAD)
        begin
            if (blocks_in_table >= MAX_BLOCKS)
            begin
                r.status = wfa_pkg::ST_FULL;
            end
            else
            begin
                block_free[blocks_in_table] = w.amount;
                r.status      = wfa_pkg::ST_LOADED;
                r.block_index = 4'(blocks_in_table);
                r.left_over   = w.amount;
                blocks_in_table++;
            end
        end
        else
        begin
            r.status = wfa_pkg::ST_NOT_ALLOCATED;
            if (blocks_in_table != 0)
            begin
                // Strictly greater keeps ties on the lowest index.
                best = 0;
                for (i = 1; i < blocks_in_table; i++)
                begin
                    if (block_free[i] > block_free[best])
                        best = i;
                end
                if (w.amount <= block_free[best])
                begin
                    block_free[best] = block_free[best] - w.amount;
                    r.status      = wfa_pkg::ST_ALLOCATED;
                    r.block_index = 4'(best);
                    r.left_over   = block_free[best];
                end
            end
        end
        return r;
    endfunction

    task automatic flag_mismatch(input bit orphan, input wfa_pkg::rsp_word_t want,
                                 input wfa_pkg::rsp_word_t got);
        if (mismatch_total < MISMATCH_REPORTS)
        begin
            if (orphan)
                $display("%0t: result word with none outstanding: %s %0d index %0d left %0h",
                         $time, "status", got.status, got.block_index, got.left_over);
            else
                $display("%0t: expected status %0d index %0d left %0h, %s %0d %s %0d %s %0h",
                         $time, want.status, want.block_index, want.left_over,
                         "got status", got.status, "index", got.block_index,
                         "left", got.left_over);
        end
        mismatch_total++;
    endtask

    always @(posedge clk)
    begin
        wfa_pkg::rsp_word_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    flag_mismatch(1'b1, '0, rsp_word);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_word.status !== want.status ||
                        rsp_word.block_index !== want.block_index ||
                        rsp_word.left_over !== want.left_over)
                        flag_mismatch(1'b0, want, rsp_word);
                end
            end
            if (req_valid && !req_stall)
                expected_results.push_back(allocate_or_load(req_word));
            owed_words = expected_results.size();
        end
    end

endmodule

/* verif/tb_worst_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// Worst-fit block allocator testbench
// Drives load and request words into the allocator: a directed opening that
// fills the table and hits the corner cases, then random words under three
// idling regimes and one long hold-off on the result side. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_worst_fit_block_allocator;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 40;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    wfa_pkg::req_word_t req_word;
    logic               rsp_valid;
    logic               rsp_stall;
    wfa_pkg::rsp_word_t rsp_word;

    int          mismatch_count;
    int          results_owed;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_off_request = 1'b0;
    int          quiet_cycles = 0;

    worst_fit_block_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    wfa_allocation_checker #(
        .MAX_BLOCKS (wfa_pkg::MAX_BLOCKS_DEF)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_word       (req_word),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp_word       (rsp_word),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Valid stays high from one word to the next unless a gap is drawn, so it
    // is never lowered and raised within the same step.
    task automatic send_word(input wfa_pkg::op_t op, input logic [15:0] amount);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid       <= 1'b1;
        req_word.op     <= op;
        req_word.amount <= amount;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Once the table is full, loads only report it full; small requests keep
    // the blocks from draining too early.
    task automatic run_random(input int unsigned count);
        int unsigned k;
        int unsigned pick;
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 12)
                send_word(wfa_pkg::OP_LOAD, 16'($urandom));
            else if (pick < 62)
                send_word(wfa_pkg::OP_REQUEST, 16'($urandom_range(127, 0)));
            else if (pick < 87)
                send_word(wfa_pkg::OP_REQUEST, 16'($urandom_range(1023, 0)));
            else if (pick < 92)
                send_word(wfa_pkg::OP_REQUEST, 16'd0);
            else
                send_word(wfa_pkg::OP_REQUEST, 16'($urandom));
        end
    endtask

    initial
    begin
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_off_request && !hold_done)
            begin
                rsp_stall <= 1'b1;
                hold_left = HOLD_OFF_CYCLES - 1;
                hold_done = 1'b1;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("worst_fit_block_allocator: mismatch");
        $finish;
    end

    initial
    begin
        int unsigned n;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_word  <= '0;
        send_idle_pct = 36;
        recv_idle_pct = 83;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Requests on an empty table, then a zero-size block.
        send_word(wfa_pkg::OP_REQUEST, 16'd5);
        send_word(wfa_pkg::OP_REQUEST, 16'd0);
        send_word(wfa_pkg::OP_LOAD, 16'd0);
        send_word(wfa_pkg::OP_REQUEST, 16'd0);
        send_word(wfa_pkg::OP_REQUEST, 16'd1);
        // Two equal largest blocks: the lower index must win, exact fit.
        send_word(wfa_pkg::OP_LOAD, 16'hFFFF);
        send_word(wfa_pkg::OP_LOAD, 16'hFFFF);
        send_word(wfa_pkg::OP_REQUEST, 16'hFFFF);
        send_word(wfa_pkg::OP_REQUEST, 16'd0);
        send_word(wfa_pkg::OP_LOAD, 16'h5555);
        send_word(wfa_pkg::OP_LOAD, 16'hAAAA);
        for (n = 0; n < 11; n++)
            send_word(wfa_pkg::OP_LOAD, 16'($urandom));
        // The table now holds every block it can; this load is refused.
        send_word(wfa_pkg::OP_LOAD, 16'hFFFF);
        send_word(wfa_pkg::OP_REQUEST, 16'hFFFF);

        run_random(320);
        send_idle_pct = 83;
        recv_idle_pct = 36;
        run_random(320);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_request = 1'b1;
        run_random(310);
        req_valid <= 1'b0;

        @(posedge clk);
        wait (results_owed == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("worst_fit_block_allocator: match");
        else
            $display("worst_fit_block_allocator: mismatch");
        $finish;
    end

endmodule

/* worst_fit_block_allocator.f */
sv/wfa_pkg.sv
sv/wfa_ctrl.sv
sv/wfa_dp.sv
sv/worst_fit_block_allocator.sv
verif/wfa_allocation_checker.sv
verif/tb_worst_fit_block_allocator.sv
